### sv/cdb_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and calendar helpers for the days-between block
// no dependencies

package cdb_pkg;

   localparam int YEAR_BITS_DEF = 12;   // default year width inside the block
   localparam int YEAR_FIELD_W  = 12;   // year width on the request port
   localparam int DAY_W         = 20;   // width of the day count result
   localparam int DOY_W         = 9;    // day of year, invalid dates included
   localparam int CENTURY       = 100;
   localparam int LEAP_DAYS     = 366;
   localparam int COMMON_DAYS   = 365;
   localparam int FEBRUARY      = 2;
   localparam logic [DAY_W-1:0] DAY_COUNT_MAX = '1;

   typedef struct packed {
      logic [YEAR_FIELD_W-1:0] later_year;
      logic [3:0]              later_month;
      logic [4:0]              later_day;
      logic [4:0]              later_hour;
      logic [5:0]              later_minute;
      logic [5:0]              later_second;
      logic [YEAR_FIELD_W-1:0] earlier_year;
      logic [3:0]              earlier_month;
      logic [4:0]              earlier_day;
      logic [4:0]              earlier_hour;
      logic [5:0]              earlier_minute;
      logic [5:0]              earlier_second;
   } req_type;

   typedef struct packed {
      logic [DAY_W-1:0] day_count;
      logic             order_error;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic reduce;
      logic walk;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic reversed;
      logic rem_ge100;
      logic at_end;
   } sts_type;

   // days before the first of the month; months past december count a whole year
   function automatic logic [DOY_W-1:0] cum_days(input logic [3:0] month);
      logic [DOY_W-1:0] res;
      case (month)
         4'd0:    res = DOY_W'(0);
         4'd1:    res = DOY_W'(0);
         4'd2:    res = DOY_W'(31);
         4'd3:    res = DOY_W'(59);
         4'd4:    res = DOY_W'(90);
         4'd5:    res = DOY_W'(120);
         4'd6:    res = DOY_W'(151);
         4'd7:    res = DOY_W'(181);
         4'd8:    res = DOY_W'(212);
         4'd9:    res = DOY_W'(243);
         4'd10:   res = DOY_W'(273);
         4'd11:   res = DOY_W'(304);
         4'd12:   res = DOY_W'(334);
         default: res = DOY_W'(COMMON_DAYS);
      endcase
      return res;
   endfunction

   function automatic logic [DOY_W-1:0] day_of_year(input logic [3:0] month,
                                                   input logic [4:0] day,
                                                   input logic       leap);
      logic [DOY_W-1:0] res;
      res = cum_days(month) + DOY_W'(day);
      if (leap && (month > 4'(FEBRUARY))) begin
         res = res + DOY_W'(1);
      end
      return res;
   endfunction

endpackage

### sv/calendar_days_between_core.sv
`timescale 1ns / 1ps
// days between two timestamps: top level joining the controller and the datapath
// depends on cdb_pkg, cdb_ctrl, cdb_datapath
//
// Usage
//   req_valid/req_ready carry one transaction: a later and an earlier timestamp
//   (year, month, day, hour, minute, second). rsp_valid/rsp_ready return one
//   result per transaction: the whole calendar days from the earlier date to the
//   later date, or a zero count with order_error set when the later timestamp
//   comes first. Hour, minute and second only take part in that order test.
//   One transaction is worked on at a time. After acceptance the earlier year is
//   reduced modulo 100 by repeated subtraction, then a year counter walks from
//   the earlier year to the later year, one year per cycle; an out of order
//   transaction skips both the reduction and the walk. The year walk sets the
//   throughput. The result sits in an output register, so the next transaction
//   is accepted and computed while a result is still stalled; that transaction
//   then waits for the slot before it is written.
//   Reset is synchronous and active high and empties the block; no results are
//   held across it.

module calendar_days_between_core #(
   parameter int YEAR_BITS = cdb_pkg::YEAR_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cdb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cdb_pkg::rsp_type rsp_payload
);

   cdb_pkg::cmd_type cmd;
   cdb_pkg::sts_type sts;

   cdb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdb_datapath #(
      .YEAR_BITS (YEAR_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

### sv/cdb_ctrl.sv
`timescale 1ns / 1ps
// sequencing fsm for the days-between block: accept, reduce, year walk, result
// depends on cdb_pkg

module cdb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  cdb_pkg::sts_type sts,
   output cdb_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_REDUCE = 4'b0010,
      S_WALK   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (sts.reversed) begin
               state_in = S_FINISH;
            end else if (sts.rem_ge100) begin
               cmd.reduce = 1'b1;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (sts.at_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold the result until the output slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_then_reduce: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_REDUCE))
      else $error("accepted transaction did not start the reduce phase");

   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over an untaken result");

   a_finish_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("result written but valid not raised");

   a_walk_only_in_order: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> !sts.reversed)
      else $error("year walk started on an out of order transaction");

endmodule

### sv/cdb_datapath.sv
`timescale 1ns / 1ps
// operand registers, century reduction, year walk accumulator and result register
// depends on cdb_pkg

module cdb_datapath #(
   parameter int YEAR_BITS = cdb_pkg::YEAR_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cdb_pkg::cmd_type cmd,
   output cdb_pkg::sts_type sts,
   input  cdb_pkg::req_type req_payload,
   output cdb_pkg::rsp_type rsp_payload
);

   // a year adds at most 366 days, so 9 bits above the year width plus a sign
   localparam int ACC_W = YEAR_BITS + 10;
   localparam int DOY_W = cdb_pkg::DOY_W;
   localparam int DAY_W = cdb_pkg::DAY_W;

   logic [YEAR_BITS-1:0] lat_year_ff;
   logic [3:0]           lat_month_ff;
   logic [4:0]           lat_day_ff;
   logic [3:0]           ear_month_ff;
   logic [4:0]           ear_day_ff;
   logic                 before_ff;
   logic                 first_ff;
   logic [YEAR_BITS-1:0] year_ff;
   logic [YEAR_BITS-1:0] rem_ff;
   logic [1:0]           cent_ff;
   logic [ACC_W-1:0]     acc_ff;
   cdb_pkg::rsp_type     rsp_ff;

   logic [YEAR_BITS-1:0] req_lat_year, req_ear_year;
   logic                 req_before;
   logic                 leap;
   logic [DOY_W-1:0]     doy_lat, doy_ear, year_len, add_term, sub_term;
   logic [ACC_W-1:0]     acc_in;
   logic [DAY_W-1:0]     day_sat;

   assign req_lat_year = YEAR_BITS'(req_payload.later_year);
   assign req_ear_year = YEAR_BITS'(req_payload.earlier_year);

   // field by field order test is one compare of the concatenated timestamps
   assign req_before =
      {req_lat_year, req_payload.later_month, req_payload.later_day,
       req_payload.later_hour, req_payload.later_minute, req_payload.later_second} <
      {req_ear_year, req_payload.earlier_month, req_payload.earlier_day,
       req_payload.earlier_hour, req_payload.earlier_minute, req_payload.earlier_second};

   // year = 100 * cent + rem, with cent kept modulo 4
   assign leap = ((year_ff[1:0] == 2'd0) && (rem_ff != '0)) ||
                 ((rem_ff == '0) && (cent_ff == 2'd0));

   assign doy_lat  = cdb_pkg::day_of_year(lat_month_ff, lat_day_ff, leap);
   assign doy_ear  = cdb_pkg::day_of_year(ear_month_ff, ear_day_ff, leap);
   assign year_len = leap ? DOY_W'(cdb_pkg::LEAP_DAYS) : DOY_W'(cdb_pkg::COMMON_DAYS);
   assign add_term = sts.at_end ? doy_lat : year_len;
   assign sub_term = first_ff ? doy_ear : '0;
   assign acc_in   = acc_ff + ACC_W'(add_term) - ACC_W'(sub_term);

   always_comb begin
      if (acc_ff[ACC_W-1]) begin
         day_sat = '0;
      end else if (acc_ff[ACC_W-2:0] > (ACC_W-1)'(cdb_pkg::DAY_COUNT_MAX)) begin
         day_sat = cdb_pkg::DAY_COUNT_MAX;
      end else begin
         day_sat = acc_ff[DAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lat_year_ff  <= req_lat_year;
         lat_month_ff <= req_payload.later_month;
         lat_day_ff   <= req_payload.later_day;
         ear_month_ff <= req_payload.earlier_month;
         ear_day_ff   <= req_payload.earlier_day;
         before_ff    <= req_before;
         first_ff     <= 1'b1;
         year_ff      <= req_ear_year;
         rem_ff       <= req_ear_year;
         cent_ff      <= 2'd0;
         acc_ff       <= '0;
      end else if (cmd.reduce) begin
         rem_ff  <= rem_ff - YEAR_BITS'(cdb_pkg::CENTURY);
         cent_ff <= cent_ff + 2'd1;
      end else if (cmd.walk) begin
         acc_ff   <= acc_in;
         first_ff <= 1'b0;
         if (!sts.at_end) begin
            year_ff <= year_ff + YEAR_BITS'(1);
            if (rem_ff == YEAR_BITS'(cdb_pkg::CENTURY - 1)) begin
               rem_ff  <= '0;
               cent_ff <= cent_ff + 2'd1;
            end else begin
               rem_ff <= rem_ff + YEAR_BITS'(1);
            end
         end
      end
      if (cmd.finish) begin
         rsp_ff.order_error <= before_ff;
         rsp_ff.day_count   <= before_ff ? '0 : day_sat;
      end
   end

   assign sts.reversed  = before_ff;
   assign sts.rem_ge100 = rem_ff >= YEAR_BITS'(cdb_pkg::CENTURY);
   assign sts.at_end    = year_ff == lat_year_ff;
   assign rsp_payload   = rsp_ff;

   a_walk_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (rem_ff < YEAR_BITS'(cdb_pkg::CENTURY)))
      else $error("year walk started before the century reduction finished");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (year_ff <= lat_year_ff))
      else $error("year walk ran past the later year");

   a_walk_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk && !sts.at_end) |=> (year_ff == $past(year_ff) + YEAR_BITS'(1)))
      else $error("year counter did not advance during the walk");

endmodule

### verif/calendar_days_between_checker.sv
`timescale 1ns / 1ps
// checker for the days-between block: watches both channels, predicts each result
// and compares it with what the block returns; depends on cdb_pkg

module calendar_days_between_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cdb_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cdb_pkg::rsp_type rsp_payload,
   output int               error_count,
   output int               outstanding
);

   cdb_pkg::rsp_type expected_days_q[$];
   cdb_pkg::rsp_type oldest_days;
   int      mismatches    = 0;
   int      pending_count = 0;

   assign error_count = mismatches;
   assign outstanding = pending_count;

   function automatic bit gregorian_leap(input longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // leap years in 1..y
   function automatic longint leaps_through(input longint y);
      return y / 4 - y / 100 + y / 400;
   endfunction

   // days ahead of the first of the month in a common year
   function automatic longint month_offset(input logic [3:0] m);
      case (m)
         4'd0, 4'd1: return 0;
         4'd2:       return 31;
         4'd3:       return 59;
         4'd4:       return 90;
         4'd5:       return 120;
         4'd6:       return 151;
         4'd7:       return 181;
         4'd8:       return 212;
         4'd9:       return 243;
         4'd10:      return 273;
         4'd11:      return 304;
         4'd12:      return 334;
         default:    return 365;
      endcase
   endfunction

   function automatic longint ordinal_day(input longint y, input logic [3:0] m,
                                          input logic [4:0] d);
      longint n;
      n = month_offset(m);
      if (m > 4'd2 && gregorian_leap(y)) begin
         n = n + 1;
      end
      return n + longint'(d);
   endfunction

   function automatic cdb_pkg::rsp_type predict_days_between(input cdb_pkg::req_type r);
      cdb_pkg::rsp_type res;
      logic [37:0]   later_key;
      logic [37:0]   earlier_key;
      longint        ya;
      longint        yb;
      longint        da;
      longint        db;
      longint        total;
      res         = '0;
      later_key   = {r.later_year, r.later_month, r.later_day,
                     r.later_hour, r.later_minute, r.later_second};
      earlier_key = {r.earlier_year, r.earlier_month, r.earlier_day,
                     r.earlier_hour, r.earlier_minute, r.earlier_second};
      if (later_key < earlier_key) begin
         res.order_error = 1'b1;
         return res;
      end
      ya = longint'(r.later_year);
      yb = longint'(r.earlier_year);
      da = ordinal_day(ya, r.later_month, r.later_day);
      db = ordinal_day(yb, r.earlier_month, r.earlier_day);
      if (ya == yb) begin
         total = da - db;
      end else begin
         total = (gregorian_leap(yb) ? 366 : 365) - db + da
                 + 365 * (ya - 1 - yb) + leaps_through(ya - 1) - leaps_through(yb);
      end
      // invalid dates can drive the count below zero; wide spans overflow it
      if (total < 0) begin
         total = 0;
      end
      if (total > 1048575) begin
         total = 1048575;
      end
      res.day_count = cdb_pkg::DAY_W'(total);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: days check: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_days_q.delete();
      end else begin
         // a response never belongs to a request taken on the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_days_q.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, day_count %0d order_error %0b",
                                         rsp_payload.day_count, rsp_payload.order_error));
            end else begin
               oldest_days = expected_days_q.pop_front();
               if (rsp_payload.day_count !== oldest_days.day_count) begin
                  report_mismatch($sformatf("day_count %0d, predicted %0d",
                                            rsp_payload.day_count, oldest_days.day_count));
               end
               if (rsp_payload.order_error !== oldest_days.order_error) begin
                  report_mismatch($sformatf("order_error %0b, predicted %0b",
                                            rsp_payload.order_error,
                                            oldest_days.order_error));
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_days_q.push_back(predict_days_between(req_payload));
         end
      end
      pending_count <= expected_days_q.size();
   end

endmodule

### verif/calendar_days_between_core_tb.sv
`timescale 1ns / 1ps
// testbench top for calendar_days_between_core: clock, reset, stimulus and verdict
// depends on cdb_pkg, calendar_days_between_core and calendar_days_between_checker

module calendar_days_between_core_tb;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             rsp_ready   = 1'b0;
   cdb_pkg::req_type req_payload = '0;
   logic             req_ready;
   logic             rsp_valid;
   cdb_pkg::rsp_type rsp_payload;
   int               error_count;
   int               outstanding;
   int               idle_pct    = 0;
   int               stall_pct   = 0;
   int               phase;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   calendar_days_between_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   calendar_days_between_checker days_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   function automatic cdb_pkg::req_type stamp_pair(
      input int unsigned ly, input int unsigned lm, input int unsigned ld,
      input int unsigned lh, input int unsigned lmi, input int unsigned ls,
      input int unsigned ey, input int unsigned em, input int unsigned ed,
      input int unsigned eh, input int unsigned emi, input int unsigned es);
      cdb_pkg::req_type r;
      r.later_year     = cdb_pkg::YEAR_FIELD_W'(ly);
      r.later_month    = 4'(lm);
      r.later_day      = 5'(ld);
      r.later_hour     = 5'(lh);
      r.later_minute   = 6'(lmi);
      r.later_second   = 6'(ls);
      r.earlier_year   = cdb_pkg::YEAR_FIELD_W'(ey);
      r.earlier_month  = 4'(em);
      r.earlier_day    = 5'(ed);
      r.earlier_hour   = 5'(eh);
      r.earlier_minute = 6'(emi);
      r.earlier_second = 6'(es);
      return r;
   endfunction

   // mostly a sensible value, now and then anything the field can hold
   function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi,
                                              input int unsigned field_max);
      if ($urandom_range(9) == 0) begin
         return $urandom_range(0, field_max);
      end
      return $urandom_range(lo, hi);
   endfunction

   function automatic cdb_pkg::req_type random_pair();
      int unsigned kind;
      int unsigned ly, lm, ld, lh, lmi, ls;
      int unsigned ey, em, ed, eh, emi, es;
      kind = $urandom_range(99);
      ey   = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1970, 4095);
      // keep most year spans short, the walk steps through every year of the span
      if (kind < 78) begin
         ly = ey + $urandom_range(0, 12);
      end else if (kind < 90) begin
         ly = ey + $urandom_range(0, 400);
      end else begin
         ly = $urandom_range(0, 4095);
         ey = $urandom_range(0, 4095);
      end
      if (ly > 4095) begin
         ly = 4095;
      end
      lm  = pick_field(1, 12, 15);
      ld  = pick_field(1, 31, 31);
      lh  = pick_field(0, 23, 31);
      lmi = pick_field(0, 59, 63);
      ls  = pick_field(0, 59, 63);
      em  = pick_field(1, 12, 15);
      ed  = pick_field(1, 31, 31);
      eh  = pick_field(0, 23, 31);
      emi = pick_field(0, 59, 63);
      es  = pick_field(0, 59, 63);
      // same date on both sides, so the time of day decides the order
      if ($urandom_range(99) < 15) begin
         ly = ey;
         lm = em;
         ld = ed;
      end
      if ($urandom_range(99) < 10) begin
         return stamp_pair(ey, em, ed, eh, emi, es, ly, lm, ld, lh, lmi, ls);
      end
      return stamp_pair(ly, lm, ld, lh, lmi, ls, ey, em, ed, eh, emi, es);
   endfunction

   // returns on the edge that takes the transaction, valid still high
   task automatic push_request(input cdb_pkg::req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // time of day alone decides, then date fields, then the year
      push_request(stamp_pair(2024, 2, 29, 12, 30, 30, 2024, 2, 29, 12, 30, 30));
      push_request(stamp_pair(2024, 2, 29, 12, 30, 29, 2024, 2, 29, 12, 30, 30));
      push_request(stamp_pair(2024, 2, 29, 12, 29, 59, 2024, 2, 29, 12, 30, 0));
      push_request(stamp_pair(2024, 2, 29, 11, 59, 59, 2024, 2, 29, 12, 0, 0));
      push_request(stamp_pair(2024, 2, 28, 23, 59, 59, 2024, 2, 29, 0, 0, 0));
      push_request(stamp_pair(2024, 1, 31, 23, 59, 59, 2024, 2, 1, 0, 0, 0));
      push_request(stamp_pair(1970, 1, 1, 0, 0, 0, 4095, 12, 31, 23, 59, 59));
      push_request(stamp_pair(2023, 6, 2, 0, 0, 0, 2023, 6, 1, 23, 59, 59));
      // field extremes, saturating count
      push_request(stamp_pair(4095, 15, 31, 31, 63, 63, 0, 0, 0, 0, 0, 0));
      push_request(stamp_pair(4095, 12, 31, 23, 59, 59, 1000, 1, 1, 0, 0, 0));
      push_request(stamp_pair(4095, 12, 31, 23, 59, 59, 1970, 1, 1, 0, 0, 0));
      // leap rule: every fourth year, not centuries, but every fourth century
      push_request(stamp_pair(2000, 3, 1, 0, 0, 0, 1999, 12, 31, 0, 0, 0));
      push_request(stamp_pair(2100, 3, 1, 0, 0, 0, 2100, 2, 28, 0, 0, 0));
      push_request(stamp_pair(2024, 3, 1, 0, 0, 0, 2024, 2, 28, 0, 0, 0));
      push_request(stamp_pair(1, 1, 1, 0, 0, 0, 0, 12, 31, 0, 0, 0));
      // month zero, months past december, day past the month end
      push_request(stamp_pair(2023, 0, 1, 0, 0, 0, 2022, 12, 31, 0, 0, 0));
      push_request(stamp_pair(2020, 13, 1, 0, 0, 0, 2020, 12, 31, 0, 0, 0));
      push_request(stamp_pair(2021, 15, 0, 0, 0, 0, 2019, 14, 3, 0, 0, 0));
      push_request(stamp_pair(2023, 2, 31, 0, 0, 0, 2023, 1, 1, 0, 0, 0));
      // invalid dates giving a negative span, clamped to zero
      push_request(stamp_pair(2023, 3, 0, 0, 0, 0, 2023, 2, 31, 0, 0, 0));
      push_request(stamp_pair(2024, 0, 0, 0, 0, 0, 2023, 15, 31, 0, 0, 0));

      for (phase = 0; phase < 4; phase++) begin
         // the sender holds off until every result is back
         drain_results();
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 64; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         repeat (63) push_request(random_pair());
      end

      drain_results();
      repeat (100) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("calendar_days_between_core_tb: clean");
      end else begin
         $display("calendar_days_between_core_tb: errors");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("calendar_days_between_core_tb: errors");
      $finish;
   end

endmodule
